// File: rtl/lcfs_pkg.sv
// Shared types and constants for the LED cube frame serializer.
package lcfs_pkg;

  localparam int BITS_PER_LED = 24;
  localparam int TOP_BIT      = 23;
  localparam logic [7:0] ALL_HIGH = 8'hFF;

  localparam logic [1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [1:0] OP_CLEAR_ALL = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_HIGH_SLOTS = 2'd0;
  localparam logic [1:0] REG_DATA_SLOTS = 2'd1;
  localparam logic [1:0] REG_LOW_SLOTS  = 2'd2;

  typedef struct packed {
    logic pix;
    logic clr;
  } store_cmd_t;

  typedef struct packed {
    logic high;
    logic data;
    logic done;
  } slot_phase_t;

endpackage

// File: rtl/lcfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module lcfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lcfs_store_ctrl.sv
// Frame store controller: clearing sweep, per-lane pixel read-modify-write, refresh reads.
module lcfs_store_ctrl #(
  parameter int LANES   = 8,
  parameter int ROWS    = 8,
  parameter int COLUMNS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lcfs_pkg::store_cmd_t     cmd,
  input  logic [3:0]               lane,
  input  logic [3:0]               row,
  input  logic [3:0]               column,
  input  logic [23:0]              color,
  input  logic [$clog2(ROWS*COLUMNS*lcfs_pkg::BITS_PER_LED)-1:0] refresh_addr,
  output logic [LANES-1:0]         word,
  output logic                     busy
);

  localparam int DEPTH  = ROWS * COLUMNS * lcfs_pkg::BITS_PER_LED;
  localparam int AW     = $clog2(DEPTH);
  localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PW     = 12;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PIXEL = 2'd2;

  logic [1:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    rd_addr;
  logic [4:0]       rd_left;
  logic             wb_valid;
  logic [AW-1:0]    wb_addr;
  logic             wb_bit;
  logic [23:0]      color_sh;
  logic [LW-1:0]    lane_idx;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [LANES-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [PW-1:0]    pix_index;
  logic [AW-1:0]    base;

  always_comb begin
    if (row[0]) begin
      pix_index = (PW'(row) - PW'(1)) * PW'(COLUMNS) + PW'(column) - PW'(1);
    end else begin
      pix_index = PW'(row) * PW'(COLUMNS) - PW'(column);
    end
    base = AW'({pix_index, 4'b0000}) + AW'({pix_index, 3'b000});
  end

  always_comb begin
    we    = 1'b0;
    waddr = wb_addr;
    wdata = word;
    raddr = refresh_addr;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      S_PIXEL: begin
        raddr = rd_addr;
        we    = wb_valid;
        wdata[lane_idx] = wb_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      rd_left  <= '0;
      wb_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (cmd.clr) begin
            state <= S_CLEAR;
          end else if (cmd.pix) begin
            state    <= S_PIXEL;
            rd_addr  <= base;
            rd_left  <= 5'(lcfs_pkg::BITS_PER_LED);
            color_sh <= color;
            lane_idx <= LW'(lane - 4'd1);
          end
        end
        S_PIXEL: begin
          wb_valid <= (rd_left != '0);
          if (rd_left != '0) begin
            wb_addr  <= rd_addr;
            wb_bit   <= color_sh[lcfs_pkg::TOP_BIT];
            color_sh <= {color_sh[22:0], 1'b0};
            rd_addr  <= rd_addr + AW'(1);
            rd_left  <= rd_left - 5'd1;
          end else if (!wb_valid) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  lcfs_ram #(
    .WIDTH(LANES),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(word)
  );

endmodule

// File: rtl/lcfs_slot_seq.sv
// Refresh sequencer: bit position and slot counter, phase of the current slot.
module lcfs_slot_seq #(
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start_go,
  input  logic                     tick_go,
  input  logic [3:0]               high_slots,
  input  logic [3:0]               data_slots,
  input  logic [3:0]               low_slots,
  output logic                     refreshing,
  output logic [$clog2(DEPTH)-1:0] bit_position,
  output lcfs_pkg::slot_phase_t    phase
);

  localparam int AW = $clog2(DEPTH);

  logic [5:0] slot_count;
  logic [5:0] total;
  logic [5:0] total_eff;
  logic [5:0] high_data;
  logic [5:0] slot_inc;
  logic       bit_end;
  logic       last_bit;

  always_comb begin
    total     = 6'(high_slots) + 6'(data_slots) + 6'(low_slots);
    total_eff = (total == '0) ? 6'd1 : total;
    high_data = 6'(high_slots) + 6'(data_slots);
    slot_inc  = slot_count + 6'd1;
    bit_end   = (slot_inc >= total_eff);
    last_bit  = (bit_position == AW'(DEPTH - 1));
    phase.high = (slot_count < 6'(high_slots));
    phase.data = !phase.high && (slot_count < high_data);
    phase.done = bit_end && last_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refreshing   <= 1'b0;
      bit_position <= '0;
      slot_count   <= '0;
    end else if (start_go) begin
      refreshing   <= 1'b1;
      bit_position <= '0;
      slot_count   <= '0;
    end else if (tick_go) begin
      if (bit_end) begin
        slot_count <= '0;
        if (last_bit) begin
          bit_position <= '0;
          refreshing   <= 1'b0;
        end else begin
          bit_position <= bit_position + AW'(1);
        end
      end else begin
        slot_count <= slot_inc;
      end
    end
  end

endmodule

// File: rtl/led_cube_frame_serializer_core.sv
// Top level of the LED cube frame serializer: command port, config port, result register.
//
//   channel   handshake                        payload
//   command   start, busy                      operation, lane, row, column, color
//   result    result_valid (one cycle)         pin_levels, busy_res, frame_done, status
//   config    psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// Every item gives its result in the cycle after it is accepted.
// Back-to-back ticks run at one per cycle (refresh read port).
// set_pixel holds busy while it runs 24 read-modify-writes through the store RAM.
// clear_all holds busy while it clears ROWS*COLUMNS*24 words (1536 by default), one word a cycle;
// the same clearing pass runs after reset. The receiver cannot stall results.
module led_cube_frame_serializer_core #(
  parameter int LANES   = 8,
  parameter int ROWS    = 8,
  parameter int COLUMNS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [3:0]  lane,
  input  logic [3:0]  row,
  input  logic [3:0]  column,
  input  logic [23:0] color,
  output logic        result_valid,
  output logic [7:0]  pin_levels,
  output logic        busy_res,
  output logic        frame_done,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = ROWS * COLUMNS * lcfs_pkg::BITS_PER_LED;
  localparam int AW    = $clog2(DEPTH);

  logic [3:0] high_slots;
  logic [3:0] data_slots;
  logic [3:0] low_slots;

  logic                  accept;
  logic                  refreshing;
  logic [AW-1:0]         bit_position;
  lcfs_pkg::slot_phase_t phase;
  lcfs_pkg::store_cmd_t  cmd;
  logic                  start_go;
  logic                  tick_go;
  logic                  in_range;
  logic                  store_busy;
  logic [LANES-1:0]      word;
  logic [7:0]            word_pins;

  logic                  res_high;
  logic                  res_data;
  logic [1:0]            status_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_slots <= 4'd2;
      data_slots <= 4'd4;
      low_slots  <= 4'd2;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        lcfs_pkg::REG_HIGH_SLOTS: high_slots <= pwdata[3:0];
        lcfs_pkg::REG_DATA_SLOTS: data_slots <= pwdata[3:0];
        lcfs_pkg::REG_LOW_SLOTS:  low_slots  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lcfs_pkg::REG_HIGH_SLOTS: prdata = 32'(high_slots);
      lcfs_pkg::REG_DATA_SLOTS: prdata = 32'(data_slots);
      lcfs_pkg::REG_LOW_SLOTS:  prdata = 32'(low_slots);
      default:                  prdata = '0;
    endcase
  end

  assign busy   = store_busy;
  assign accept = start && !busy;

  assign in_range = (lane != 4'd0) && (32'(lane) <= LANES) &&
                    (row != 4'd0) && (32'(row) <= ROWS) &&
                    (column != 4'd0) && (32'(column) <= COLUMNS);

  always_comb begin
    cmd.pix     = accept && !refreshing && in_range &&
                  (operation == lcfs_pkg::OP_SET_PIXEL);
    cmd.clr     = accept && !refreshing && (operation == lcfs_pkg::OP_CLEAR_ALL);
    start_go    = accept && !refreshing && (operation == lcfs_pkg::OP_START);
    tick_go     = accept && refreshing && (operation == lcfs_pkg::OP_TICK);
    status_next = lcfs_pkg::ST_OK;
    if (operation != lcfs_pkg::OP_TICK && refreshing) begin
      status_next = lcfs_pkg::ST_BUSY;
    end else if (operation == lcfs_pkg::OP_SET_PIXEL && !in_range) begin
      status_next = lcfs_pkg::ST_RANGE;
    end
  end

  lcfs_slot_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start_go    (start_go),
    .tick_go     (tick_go),
    .high_slots  (high_slots),
    .data_slots  (data_slots),
    .low_slots   (low_slots),
    .refreshing  (refreshing),
    .bit_position(bit_position),
    .phase       (phase)
  );

  lcfs_store_ctrl #(
    .LANES  (LANES),
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .lane        (lane),
    .row         (row),
    .column      (column),
    .color       (color),
    .refresh_addr(bit_position),
    .word        (word),
    .busy        (store_busy)
  );

  for (genvar i = 0; i < 8; i++) begin : g_pins
    if (i < LANES) begin : g_lane
      assign word_pins[i] = word[i];
    end else begin : g_none
      assign word_pins[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      res_high     <= 1'b0;
      res_data     <= 1'b0;
      frame_done   <= 1'b0;
      busy_res     <= 1'b0;
      status       <= lcfs_pkg::ST_OK;
    end else begin
      result_valid <= accept;
      if (accept) begin
        res_high   <= tick_go && phase.high;
        res_data   <= tick_go && phase.data;
        frame_done <= tick_go && phase.done;
        busy_res   <= refreshing || start_go;
        status     <= status_next;
      end
    end
  end

  always_comb begin
    if (res_high) begin
      pin_levels = lcfs_pkg::ALL_HIGH;
    end else if (res_data) begin
      pin_levels = word_pins;
    end else begin
      pin_levels = 8'h00;
    end
  end

endmodule

// File: rtl/lcfs_checker.sv
// Port-level checks for the LED cube frame serializer, bound to the top level.
module lcfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [7:0] pin_levels,
  input logic       busy_res,
  input logic       frame_done,
  input logic [1:0] status
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> result_valid)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy))
    else $error("result without an accepted item");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_done |-> busy_res && status == lcfs_pkg::ST_OK)
    else $error("frame end outside a refresh");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != lcfs_pkg::ST_OK |-> pin_levels == 8'h00 && !frame_done)
    else $error("rejected item drove pins");

endmodule

bind led_cube_frame_serializer_core lcfs_checker u_lcfs_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .pin_levels  (pin_levels),
  .busy_res    (busy_res),
  .frame_done  (frame_done),
  .status      (status)
);
